// ----- rtl/itch_message_stream_parser_macros.svh -----
// Assertion macros for the market-feed frame parser.
// No dependencies; included by the top level.
`ifndef ITCH_MESSAGE_STREAM_PARSER_MACROS_SVH
`define ITCH_MESSAGE_STREAM_PARSER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define IMP_ASSERT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define NXT_ASSERT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ----- rtl/imsp_pkg.sv -----
// Package for the market-feed frame parser: types, codes and helpers.
// No dependencies.
package imsp_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw = $clog2(QueueDepth);

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_SHORT_PREFIX = 3'd1, ST_SHORT_BODY = 3'd2, ST_EMPTY = 3'd3,
      ST_UNKNOWN = 3'd4, ST_TOO_SHORT = 3'd5, ST_BAD_SIDE = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PH_LEN_HI = 2'd0, PH_LEN_LO = 2'd1, PH_BODY = 2'd2
   } phase_type;

   // message kind codes, in result order; K_NONE marks an unknown type byte
   typedef enum logic [3:0] {
      K_R = 4'd0, K_L = 4'd1, K_A = 4'd2, K_F = 4'd3, K_E = 4'd4,
      K_C = 4'd5, K_X = 4'd6, K_D = 4'd7, K_U = 4'd8, K_P = 4'd9, K_NONE = 4'd10
   } kind_type;

   localparam logic [7:0] ChR = 8'h52;
   localparam logic [7:0] ChL = 8'h4C;
   localparam logic [7:0] ChA = 8'h41;
   localparam logic [7:0] ChF = 8'h46;
   localparam logic [7:0] ChE = 8'h45;
   localparam logic [7:0] ChC = 8'h43;
   localparam logic [7:0] ChX = 8'h58;
   localparam logic [7:0] ChD = 8'h44;
   localparam logic [7:0] ChU = 8'h55;
   localparam logic [7:0] ChP = 8'h50;
   localparam logic [7:0] ChY = 8'h59;
   localparam logic [7:0] ChB = 8'h42;
   localparam logic [7:0] ChS = 8'h53;
   localparam logic [7:0] ChSpace = 8'h20;

   // finished frame as handed from front to back
   typedef struct packed {
      status_type  status;
      logic [7:0]  type_byte;
      logic [15:0] frame_length;
      logic [7:0]  side_byte;
      logic [511:0] body;
   } frame_type;

   // kind code from a type byte; K_NONE means unknown
   function automatic logic [3:0] kind_of(input logic [7:0] t);
      case (t)
         ChR: kind_of = K_R;
         ChL: kind_of = K_L;
         ChA: kind_of = K_A;
         ChF: kind_of = K_F;
         ChE: kind_of = K_E;
         ChC: kind_of = K_C;
         ChX: kind_of = K_X;
         ChD: kind_of = K_D;
         ChU: kind_of = K_U;
         ChP: kind_of = K_P;
         default: kind_of = K_NONE;
      endcase
   endfunction

   function automatic logic [15:0] kind_min(input logic [3:0] k);
      case (k)
         K_R: kind_min = 16'd39;
         K_L: kind_min = 16'd26;
         K_A: kind_min = 16'd36;
         K_F: kind_min = 16'd40;
         K_E: kind_min = 16'd23;
         K_C: kind_min = 16'd36;
         K_X: kind_min = 16'd23;
         K_D: kind_min = 16'd19;
         K_U: kind_min = 16'd35;
         default: kind_min = 16'd36;
      endcase
   endfunction

endpackage

// ----- rtl/imsp_front.sv -----
// Front part: framing and byte capture, one byte per cycle while in_valid is high.
// Depends on imsp_pkg.
module imsp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           data_byte,
   input  logic                 buffer_end,
   output logic                 frame_valid,
   output imsp_pkg::frame_type  frame
);

   imsp_pkg::phase_type phase_ff, phase_in;
   logic [15:0]  pos_ff, pos_in;
   logic [15:0]  len_ff, len_in;
   logic [7:0]   type_ff, type_in;
   logic [7:0]   side_ff, side_in;
   logic [511:0] body_ff, body_in;
   logic [15:0]  full_len;

   assign full_len = {len_ff[15:8], data_byte};

   // framing and capture
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      type_in = type_ff;
      side_in = side_ff;
      body_in = body_ff;
      frame_valid = 1'b0;
      frame = '0;
      frame.status = imsp_pkg::ST_OK;
      if (in_valid) begin
         case (phase_ff)
            imsp_pkg::PH_LEN_HI: begin
               len_in = {data_byte, 8'h00};
               if (buffer_end) begin
                  frame_valid = 1'b1;
                  frame.status = imsp_pkg::ST_SHORT_PREFIX;
               end else begin
                  phase_in = imsp_pkg::PH_LEN_LO;
               end
            end
            imsp_pkg::PH_LEN_LO: begin
               len_in = full_len;
               body_in = '0;
               type_in = '0;
               side_in = '0;
               pos_in = '0;
               if (full_len == 16'd0 || buffer_end) begin
                  frame_valid = 1'b1;
                  frame.status = (full_len == 16'd0) ? imsp_pkg::ST_EMPTY
                                                     : imsp_pkg::ST_SHORT_BODY;
                  phase_in = imsp_pkg::PH_LEN_HI;
               end else begin
                  phase_in = imsp_pkg::PH_BODY;
               end
            end
            default: begin
               if (pos_ff < 16'd64)
                  body_in[511 - 8 * pos_ff[5:0] -: 8] = data_byte;
               if (pos_ff == 16'd0) type_in = data_byte;
               if (pos_ff == 16'd19) side_in = data_byte;
               pos_in = pos_ff + 16'd1;
               if (pos_ff + 16'd1 >= len_ff) begin
                  frame_valid = 1'b1;
                  frame.status = imsp_pkg::ST_OK;
                  frame.type_byte = type_in;
                  frame.side_byte = side_in;
                  frame.frame_length = len_ff;
                  frame.body = body_in;
                  phase_in = imsp_pkg::PH_LEN_HI;
               end else if (buffer_end) begin
                  frame_valid = 1'b1;
                  frame.status = imsp_pkg::ST_SHORT_BODY;
                  phase_in = imsp_pkg::PH_LEN_HI;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= imsp_pkg::PH_LEN_HI;
      end else begin
         phase_ff <= phase_in;
      end
      pos_ff <= pos_in;
      len_ff <= len_in;
      type_ff <= type_in;
      side_ff <= side_in;
      body_ff <= body_in;
   end

endmodule

// ----- rtl/imsp_queue.sv -----
// Short queue between front and back parts, with full/empty flags.
// Depends on imsp_pkg.
module imsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  imsp_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output imsp_pkg::frame_type pop_data,
   output logic                empty
);

   localparam int unsigned Aw = imsp_pkg::QueueAw;

   imsp_pkg::frame_type mem_ff [imsp_pkg::QueueDepth];
   logic [Aw-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [Aw:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full = (cnt_ff == (Aw+1)'(imsp_pkg::QueueDepth));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ----- rtl/imsp_back.sv -----
// Back part: decodes a finished frame into result fields, registered output.
// Depends on imsp_pkg.
module imsp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_valid,
   input  imsp_pkg::frame_type frame,
   output logic                take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [2:0]          rsp_status,
   output logic [3:0]          rsp_kind,
   output logic [15:0]         rsp_locate,
   output logic [47:0]         rsp_event_time,
   output logic [63:0]         rsp_order_ref,
   output logic [63:0]         rsp_prior_order_ref,
   output logic [31:0]         rsp_amount,
   output logic [31:0]         rsp_raw_price,
   output logic                rsp_is_sell,
   output logic [63:0]         rsp_ticker,
   output logic [31:0]         rsp_participant,
   output logic [63:0]         rsp_attributes
);

   logic        full_ff;
   logic [2:0]  status_ff, status_in;
   logic [3:0]  kind_ff, kind_in;
   logic [15:0] locate_ff, locate_in;
   logic [47:0] time_ff, time_in;
   logic [63:0] ref_ff, ref_in, prior_ff, prior_in, ticker_ff, ticker_in;
   logic [63:0] attr_ff, attr_in;
   logic [31:0] amount_ff, amount_in, price_ff, price_in, part_ff, part_in;
   logic        sell_ff, sell_in;
   logic [3:0]  k;

   function automatic logic [7:0] bb(input logic [511:0] b, input int unsigned i);
      bb = b[511 - 8 * i -: 8];
   endfunction

   function automatic logic [31:0] be4(input logic [511:0] b, input int unsigned o);
      be4 = b[511 - 8 * o -: 32];
   endfunction

   function automatic logic [63:0] be8(input logic [511:0] b, input int unsigned o);
      be8 = b[511 - 8 * o -: 64];
   endfunction

   // zero trailing spaces from the low byte up
   function automatic logic [63:0] trim(input logic [63:0] v, input int unsigned n);
      logic       stop;
      logic [63:0] r;
      stop = 1'b0;
      r = v;
      for (int unsigned j = 0; j < 8; j++) begin
         if (j < n && !stop) begin
            if (r[8*j +: 8] == imsp_pkg::ChSpace) r[8*j +: 8] = 8'h00;
            else stop = 1'b1;
         end
      end
      trim = r;
   endfunction

   function automatic logic flag(input logic [511:0] b, input int unsigned i);
      flag = (bb(b, i) == imsp_pkg::ChY);
   endfunction

   assign take = frame_valid && (!full_ff || rsp_pop);
   assign rsp_empty = !full_ff;
   assign k = imsp_pkg::kind_of(frame.type_byte);

   // field decode
   always_comb begin
      status_in = frame.status;
      kind_in = '0; locate_in = '0; time_in = '0; ref_in = '0; prior_in = '0;
      amount_in = '0; price_in = '0; sell_in = 1'b0; ticker_in = '0;
      part_in = '0; attr_in = '0;
      if (frame.status == imsp_pkg::ST_OK) begin
         if (k == imsp_pkg::K_NONE) begin
            status_in = imsp_pkg::ST_UNKNOWN;
         end else begin
            kind_in = k;
            if (frame.frame_length < imsp_pkg::kind_min(k)) begin
               status_in = imsp_pkg::ST_TOO_SHORT;
            end else if ((k == imsp_pkg::K_A || k == imsp_pkg::K_F || k == imsp_pkg::K_P) &&
                         frame.side_byte != imsp_pkg::ChB &&
                         frame.side_byte != imsp_pkg::ChS) begin
               status_in = imsp_pkg::ST_BAD_SIDE;
            end else begin
               locate_in = frame.body[503:488];
               time_in = frame.body[471:424];
               case (k)
                  imsp_pkg::K_R: begin
                     ticker_in = trim(be8(frame.body, 11), 8);
                     amount_in = be4(frame.body, 21);
                     price_in = be4(frame.body, 34);
                     attr_in = {bb(frame.body, 19), bb(frame.body, 20),
                                bb(frame.body, 26),
                                16'(trim({48'd0, bb(frame.body, 27), bb(frame.body, 28)},
                                         2)),
                                bb(frame.body, 29), bb(frame.body, 32), 3'b000,
                                flag(frame.body, 25), flag(frame.body, 30),
                                flag(frame.body, 31), flag(frame.body, 33),
                                flag(frame.body, 38)};
                  end
                  imsp_pkg::K_L: begin
                     part_in = 32'(trim({32'd0, be4(frame.body, 11)}, 4));
                     ticker_in = trim(be8(frame.body, 15), 8);
                     attr_in = {47'd0, flag(frame.body, 23), bb(frame.body, 24),
                                bb(frame.body, 25)};
                  end
                  imsp_pkg::K_A, imsp_pkg::K_F, imsp_pkg::K_P: begin
                     ref_in = be8(frame.body, 11);
                     sell_in = (frame.side_byte == imsp_pkg::ChS);
                     amount_in = be4(frame.body, 20);
                     price_in = be4(frame.body, 32);
                     if (k == imsp_pkg::K_F)
                        part_in = 32'(trim({32'd0, be4(frame.body, 36)}, 4));
                  end
                  imsp_pkg::K_E, imsp_pkg::K_C, imsp_pkg::K_X: begin
                     ref_in = be8(frame.body, 11);
                     amount_in = be4(frame.body, 19);
                     if (k == imsp_pkg::K_C) price_in = be4(frame.body, 32);
                  end
                  imsp_pkg::K_D: ref_in = be8(frame.body, 11);
                  default: begin
                     prior_in = be8(frame.body, 11);
                     ref_in = be8(frame.body, 19);
                     amount_in = be4(frame.body, 27);
                     price_in = be4(frame.body, 31);
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (take) begin
         full_ff <= 1'b1;
      end else if (rsp_pop) begin
         full_ff <= 1'b0;
      end
      if (take) begin
         status_ff <= status_in; kind_ff <= kind_in; locate_ff <= locate_in;
         time_ff <= time_in; ref_ff <= ref_in; prior_ff <= prior_in;
         amount_ff <= amount_in; price_ff <= price_in; sell_ff <= sell_in;
         ticker_ff <= ticker_in; part_ff <= part_in; attr_ff <= attr_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_kind = kind_ff;
   assign rsp_locate = locate_ff;
   assign rsp_event_time = time_ff;
   assign rsp_order_ref = ref_ff;
   assign rsp_prior_order_ref = prior_ff;
   assign rsp_amount = amount_ff;
   assign rsp_raw_price = price_ff;
   assign rsp_is_sell = sell_ff;
   assign rsp_ticker = ticker_ff;
   assign rsp_participant = part_ff;
   assign rsp_attributes = attr_ff;

endmodule

// ----- rtl/itch_message_stream_parser.sv -----
// Market-feed frame parser: one byte accepted per cycle when not full.
// A frame's result reaches the ports through the queue write, then the
// registered decode once the output register is free.
// Throughput: one byte per cycle. The four-entry frame queue fills only when
// results are popped more slowly than frames arrive; then input stalls.
// Synchronous reset clears framing and queue state; no clearing pass.
`include "itch_message_stream_parser_macros.svh"
module itch_message_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_buffer_end,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_kind,
   output logic [15:0] rsp_locate,
   output logic [47:0] rsp_event_time,
   output logic [63:0] rsp_order_ref,
   output logic [63:0] rsp_prior_order_ref,
   output logic [31:0] rsp_amount,
   output logic [31:0] rsp_raw_price,
   output logic        rsp_is_sell,
   output logic [63:0] rsp_ticker,
   output logic [31:0] rsp_participant,
   output logic [63:0] rsp_attributes
);

   logic                f_valid, q_full, q_empty, take;
   imsp_pkg::frame_type f_frame, q_frame;

   assign full = q_full;

   imsp_front u_front (
      .clock(clock), .reset(reset), .in_valid(push && !q_full),
      .data_byte(req_data_byte), .buffer_end(req_buffer_end),
      .frame_valid(f_valid), .frame(f_frame)
   );

   imsp_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_data(f_frame),
      .full(q_full), .pop(take), .pop_data(q_frame), .empty(q_empty)
   );

   imsp_back u_back (
      .clock(clock), .reset(reset), .frame_valid(!q_empty), .frame(q_frame),
      .take(take), .rsp_empty(empty), .rsp_pop(pop),
      .rsp_status(rsp_status), .rsp_kind(rsp_kind), .rsp_locate(rsp_locate),
      .rsp_event_time(rsp_event_time), .rsp_order_ref(rsp_order_ref),
      .rsp_prior_order_ref(rsp_prior_order_ref), .rsp_amount(rsp_amount),
      .rsp_raw_price(rsp_raw_price), .rsp_is_sell(rsp_is_sell),
      .rsp_ticker(rsp_ticker), .rsp_participant(rsp_participant),
      .rsp_attributes(rsp_attributes)
   );

   `IMP_ASSERT(a_no_push_when_full, clock, reset, q_full, !(f_valid))
   `NXT_ASSERT(a_take_fills_output, clock, reset, take, !empty)
   `IMP_ASSERT(a_status_range, clock, reset, !empty, rsp_status != 3'd7)

endmodule

// ----- tb/tb_itch_message_stream_parser.sv -----
// Testbench for the market-feed frame parser: random and directed byte streams.
// Depends on imsp_pkg and the itch_message_stream_parser RTL.
`timescale 1ns / 100ps
module tb_itch_message_stream_parser;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  kind;
      logic [15:0] locate;
      logic [47:0] event_time;
      logic [63:0] order_ref;
      logic [63:0] prior_order_ref;
      logic [31:0] amount;
      logic [31:0] raw_price;
      logic        is_sell;
      logic [63:0] ticker;
      logic [31:0] participant;
      logic [63:0] attributes;
   } parse_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic [7:0] req_data_byte = '0;
   logic req_buffer_end = 1'b0;
   logic full, empty;
   parse_result_type rsp;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned recv_hold_cycles = 0;
   int errors = 0;

   // predictor state
   logic [16:0]  frame_pos = '0;
   logic [15:0]  frame_len = '0;
   logic [7:0]   type_b = '0;
   logic [7:0]   side_b = '0;
   logic [7:0]   body_mem [64];
   parse_result_type expected_results [$];

   itch_message_stream_parser i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_data_byte(req_data_byte), .req_buffer_end(req_buffer_end),
      .empty(empty), .pop(pop),
      .rsp_status(rsp.status), .rsp_kind(rsp.kind), .rsp_locate(rsp.locate),
      .rsp_event_time(rsp.event_time), .rsp_order_ref(rsp.order_ref),
      .rsp_prior_order_ref(rsp.prior_order_ref), .rsp_amount(rsp.amount),
      .rsp_raw_price(rsp.raw_price), .rsp_is_sell(rsp.is_sell),
      .rsp_ticker(rsp.ticker), .rsp_participant(rsp.participant),
      .rsp_attributes(rsp.attributes)
   );

   always #5 clock = ~clock;

   // big-endian field from captured body bytes
   function automatic logic [63:0] be_field(int off, int n);
      logic [63:0] v;
      v = '0;
      for (int k = 0; k < n; k++) v = (v << 8) | body_mem[off + k];
      return v;
   endfunction

   // zero trailing space characters of an n-byte field
   function automatic logic [63:0] strip_spaces(logic [63:0] v, int n);
      for (int k = 0; k < n; k++) begin
         if (v[8*k +: 8] != imsp_pkg::ChSpace) break;
         v[8*k +: 8] = 8'h00;
      end
      return v;
   endfunction

   function automatic logic yes_flag(int off);
      return body_mem[off] == imsp_pkg::ChY;
   endfunction

   // decode a completed frame
   function automatic parse_result_type decode_frame();
      parse_result_type r;
      logic [3:0] k;
      r = '0;
      k = imsp_pkg::kind_of(type_b);
      if (k == imsp_pkg::K_NONE) begin
         r.status = imsp_pkg::ST_UNKNOWN;
         return r;
      end
      r.kind = k;
      if (frame_len < imsp_pkg::kind_min(k)) begin
         r.status = imsp_pkg::ST_TOO_SHORT;
         return r;
      end
      if ((k == imsp_pkg::K_A || k == imsp_pkg::K_F || k == imsp_pkg::K_P) &&
          side_b != imsp_pkg::ChB && side_b != imsp_pkg::ChS) begin
         r.status = imsp_pkg::ST_BAD_SIDE;
         return r;
      end
      r.status = imsp_pkg::ST_OK;
      r.locate = 16'(be_field(1, 2));
      r.event_time = 48'(be_field(5, 6));
      case (imsp_pkg::kind_type'(k))
         imsp_pkg::K_R: begin
            r.ticker = strip_spaces(be_field(11, 8), 8);
            r.amount = 32'(be_field(21, 4));
            r.raw_price = 32'(be_field(34, 4));
            r.attributes = {body_mem[19], body_mem[20], body_mem[26],
               16'(strip_spaces(be_field(27, 2), 2)), body_mem[29], body_mem[32],
               3'b000, yes_flag(25), yes_flag(30), yes_flag(31), yes_flag(33),
               yes_flag(38)};
         end
         imsp_pkg::K_L: begin
            r.participant = 32'(strip_spaces(be_field(11, 4), 4));
            r.ticker = strip_spaces(be_field(15, 8), 8);
            r.attributes = {47'd0, yes_flag(23), body_mem[24], body_mem[25]};
         end
         imsp_pkg::K_A, imsp_pkg::K_F, imsp_pkg::K_P: begin
            r.order_ref = be_field(11, 8);
            r.is_sell = side_b == imsp_pkg::ChS;
            r.amount = 32'(be_field(20, 4));
            r.raw_price = 32'(be_field(32, 4));
            if (k == imsp_pkg::K_F) r.participant = 32'(strip_spaces(be_field(36, 4), 4));
         end
         imsp_pkg::K_E, imsp_pkg::K_C, imsp_pkg::K_X: begin
            r.order_ref = be_field(11, 8);
            r.amount = 32'(be_field(19, 4));
            if (k == imsp_pkg::K_C) r.raw_price = 32'(be_field(32, 4));
         end
         imsp_pkg::K_D: r.order_ref = be_field(11, 8);
         default: begin
            r.prior_order_ref = be_field(11, 8);
            r.order_ref = be_field(19, 8);
            r.amount = 32'(be_field(27, 4));
            r.raw_price = 32'(be_field(31, 4));
         end
      endcase
      return r;
   endfunction

   // advance the predictor by one accepted byte
   task automatic predict_byte(logic [7:0] b, logic fin);
      parse_result_type r;
      int i;
      r = '0;
      if (frame_pos == 0) begin
         frame_len = {b, 8'h00};
         if (fin) begin
            r.status = imsp_pkg::ST_SHORT_PREFIX;
            expected_results.push_back(r);
         end else frame_pos = 1;
      end else if (frame_pos == 1) begin
         frame_len[7:0] = b;
         foreach (body_mem[j]) body_mem[j] = 8'h00;
         type_b = '0;
         side_b = '0;
         if (frame_len == 0 || fin) begin
            r.status = (frame_len == 0) ? imsp_pkg::ST_EMPTY : imsp_pkg::ST_SHORT_BODY;
            expected_results.push_back(r);
            frame_pos = 0;
         end else frame_pos = 2;
      end else begin
         i = frame_pos - 2;
         if (i < 64) body_mem[i] = b;
         if (i == 0) type_b = b;
         if (i == 19) side_b = b;
         if (i + 1 >= frame_len) begin
            expected_results.push_back(decode_frame());
            frame_pos = 0;
         end else if (fin) begin
            r.status = imsp_pkg::ST_SHORT_BODY;
            expected_results.push_back(r);
            frame_pos = 0;
         end else frame_pos = frame_pos + 1;
      end
   endtask

   // offer one byte until accepted, with random idle cycles first;
   // entered and left at a falling edge, push stays high after acceptance
   task automatic send_byte(logic [7:0] b, logic fin);
      if ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      push <= 1'b1;
      req_data_byte <= b;
      req_buffer_end <= fin;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_byte(b, fin);
      @(negedge clock);
   endtask

   // result side: random pop, optional long hold-off
   always @(negedge clock) begin
      if (recv_hold_cycles > 0) begin
         pop <= 1'b0;
         recv_hold_cycles <= recv_hold_cycles - 1;
      end else pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // compare each popped result with the oldest expectation
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && pop && !empty) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result status=%0d", rsp.status);
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp.status); errors++; end
            if (rsp.kind !== e.kind) begin
               $error("kind exp %0d got %0d", e.kind, rsp.kind); errors++; end
            if (rsp.locate !== e.locate) begin
               $error("locate exp %h got %h", e.locate, rsp.locate); errors++; end
            if (rsp.event_time !== e.event_time) begin
               $error("event_time exp %h got %h", e.event_time, rsp.event_time);
               errors++; end
            if (rsp.order_ref !== e.order_ref) begin
               $error("order_ref exp %h got %h", e.order_ref, rsp.order_ref); errors++; end
            if (rsp.prior_order_ref !== e.prior_order_ref) begin
               $error("prior_order_ref exp %h got %h", e.prior_order_ref,
                  rsp.prior_order_ref); errors++; end
            if (rsp.amount !== e.amount) begin
               $error("amount exp %h got %h", e.amount, rsp.amount); errors++; end
            if (rsp.raw_price !== e.raw_price) begin
               $error("raw_price exp %h got %h", e.raw_price, rsp.raw_price); errors++; end
            if (rsp.is_sell !== e.is_sell) begin
               $error("is_sell exp %b got %b", e.is_sell, rsp.is_sell); errors++; end
            if (rsp.ticker !== e.ticker) begin
               $error("ticker exp %h got %h", e.ticker, rsp.ticker); errors++; end
            if (rsp.participant !== e.participant) begin
               $error("participant exp %h got %h", e.participant, rsp.participant);
               errors++; end
            if (rsp.attributes !== e.attributes) begin
               $error("attributes exp %h got %h", e.attributes, rsp.attributes);
               errors++; end
         end
      end
   end

   // random-looking field byte: often spaces, Y, 0xFF or 0x00 to hit decode cases
   function automatic logic [7:0] body_fill();
      case ($urandom_range(7))
         0: return imsp_pkg::ChSpace;
         1: return imsp_pkg::ChY;
         2: return 8'hFF;
         3: return 8'h00;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // send one whole frame; cut_at < 0 means no early buffer end
   task automatic send_frame(logic [7:0] tb_type, int body_len, int side_sel, int cut_at);
      logic [7:0] b;
      send_byte(body_len[15:8], cut_at == 0);
      if (cut_at == 0) return;
      send_byte(body_len[7:0], cut_at == 1);
      if (cut_at == 1 || body_len == 0) return;
      for (int i = 0; i < body_len; i++) begin
         if (i == 0) b = tb_type;
         else if (i == 19)
            b = side_sel == 0 ? imsp_pkg::ChB : side_sel == 1 ? imsp_pkg::ChS : body_fill();
         else if (i >= 11 && i <= 45 && $urandom_range(3) == 0) b = imsp_pkg::ChSpace;
         else b = body_fill();
         send_byte(b, (cut_at == i + 2) || (i == body_len - 1 && $urandom_range(9) == 0));
         if (cut_at == i + 2) return;
      end
   endtask

   function automatic logic [7:0] kind_char(int k);
      case (k)
         imsp_pkg::K_R: return imsp_pkg::ChR;
         imsp_pkg::K_L: return imsp_pkg::ChL;
         imsp_pkg::K_A: return imsp_pkg::ChA;
         imsp_pkg::K_F: return imsp_pkg::ChF;
         imsp_pkg::K_E: return imsp_pkg::ChE;
         imsp_pkg::K_C: return imsp_pkg::ChC;
         imsp_pkg::K_X: return imsp_pkg::ChX;
         imsp_pkg::K_D: return imsp_pkg::ChD;
         imsp_pkg::K_U: return imsp_pkg::ChU;
         default: return imsp_pkg::ChP;
      endcase
   endfunction

   // stop offering, wait for all results, resume at a falling edge
   task automatic wait_drained();
      push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // every message kind at its minimum length, both sides, plus error frames
   task automatic test_directed();
      for (int k = 0; k < 10; k++)
         send_frame(kind_char(k), imsp_pkg::kind_min(4'(k)), k % 2, -1);
      send_frame(imsp_pkg::ChA, 36, 2, -1);       // bad side
      send_frame(imsp_pkg::ChU, 34, 0, -1);       // too short
      send_frame("Z", 5, 0, -1);                  // unknown type
      send_frame(imsp_pkg::ChA, 0, 0, -1);        // empty frame
      send_frame(imsp_pkg::ChR, 39, 0, 0);        // short prefix
      send_frame(imsp_pkg::ChR, 39, 0, 1);        // cut after length
      send_frame(imsp_pkg::ChF, 40, 1, 20);       // cut inside body
      send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);  // empty at buffer end
      send_frame(imsp_pkg::ChD, 70, 0, -1);       // extra bytes past 64
      wait_drained();
   endtask

   // random frames: mostly well formed, some noise
   task automatic test_random(int n_bytes);
      int sent;
      int k;
      int len;
      sent = 0;
      while (sent < n_bytes) begin
         k = $urandom_range(9);
         len = imsp_pkg::kind_min(4'(k)) + $urandom_range(4);
         case ($urandom_range(9))
            0: len = $urandom_range(imsp_pkg::kind_min(4'(k)));
            1: len = $urandom_range(3);
            default: ;
         endcase
         if ($urandom_range(19) == 0)
            send_frame(8'($urandom_range(255)), len, 2, -1);
         else
            send_frame(kind_char(k), len, $urandom_range(9) == 0 ? 2 : $urandom_range(1),
               $urandom_range(14) == 0 ? $urandom_range(len + 1) : -1);
         sent += len + 2;
      end
      wait_drained();
   endtask

   // receiver stops while sender keeps pushing, so the queue fills
   task automatic test_backpressure();
      @(negedge clock);
      recv_hold_cycles = 300;
      for (int i = 0; i < 8; i++) send_frame(imsp_pkg::ChD, 19, 0, -1);
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 12; recv_idle_pct = 65;
      test_random(200);
      send_idle_pct = 65; recv_idle_pct = 12;
      test_random(200);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(200);
      test_backpressure();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ----- itch_message_stream_parser.f -----
+incdir+rtl
rtl/imsp_pkg.sv
rtl/imsp_front.sv
rtl/imsp_queue.sv
rtl/imsp_back.sv
rtl/itch_message_stream_parser.sv
tb/tb_itch_message_stream_parser.sv
